// ===== design/cobt_pkg.sv =====
// Shared types and constants for the carbs-on-board table.
package cobt_pkg;

  // Register indexes on the configuration channel.
  localparam logic REG_DEFAULT_ABSORPTION = 1'b0;
  localparam logic REG_TABLE_LIMIT        = 1'b1;

  // Command codes carried on the input tuser.
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [15:0] FALLBACK_ABSORB_MINUTES = 16'd180;
  localparam logic [5:0]  SECONDS_PER_MINUTE      = 6'd60;
  localparam logic [20:0] COB_MAX                 = 21'h1F_FFFF;
  localparam int unsigned QUOT_BITS               = 16;

  // One meal record as held in the table memory.
  typedef struct packed {
    logic [15:0] duration;
    logic [15:0] carbs;
    logic [31:0] meal_time;
  } meal_rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_ACC,
    S_FINISH,
    S_WRAP,
    S_EMIT
  } state_t;

endpackage

// ===== design/carbs_on_board_table_core.sv =====
// Top level of the carbs-on-board table: meal ring memory and update walk.
//
//  Channel | Direction | Signals                         | Content
//  --------+-----------+---------------------------------+--------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser | one command per transfer
//  m_      | out       | m_tvalid m_tready m_tdata       | one result per command
//  cfg_    | in        | cfg_valid cfg_ready cfg_index cfg_data | register writes
//
// An add goes through the ring wrap step to its result; a rejected command goes straight to it.
// An update walks the held entries and then finishes and wraps; each entry that is kept
// passes memory read, check, multiply, a 16-step restoring divide shared by all entries and
// accumulate, while an entry that is dropped stops after the check.
// Reset is synchronous and clears the valid bits, so no clearing pass is needed.
// One command is worked on at a time; the result waits in the output register
// and the next command is taken once the result has been loaded there.
module carbs_on_board_table_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // time_s[31:0], carbs[47:32], absorb_minutes[63:48]
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // accepted[0], carbs_on_board[21:1], meal_count[27:22]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = 16 + CW;
  localparam int QW = cobt_pkg::QUOT_BITS;
  localparam int NW = $clog2(QW);

  cobt_pkg::state_t state, state_next;

  // Configuration registers.
  logic [15:0] dflt_absorb_minutes;
  logic [5:0]  table_limit;
  logic [CW-1:0] lim;

  // Table memory, valid bits and control state.
  cobt_pkg::meal_rec_t mem [TABLE_DEPTH];
  cobt_pkg::meal_rec_t rd, rec;
  logic [TABLE_DEPTH-1:0] valid;
  logic [CW-1:0] ptr, held, held_walk, idx, kept;
  logic [31:0] last_update_time, last_meal_time, now;
  logic [20:0] cob_total;
  logic        accepted;

  // Walk datapath.
  logic [21:0] dur_s, rem, divisor, rdiv;
  logic [QW-1:0] low, quot;
  logic [NW-1:0] cnt;
  logic [SW-1:0] sum;

  // Output register.
  logic        out_valid;
  logic [31:0] out_data;

  logic        in_fire, add_ok, upd_ok, check_ok, walk_last;
  logic [31:0] in_time, age;
  logic [15:0] in_carbs, in_absorb;
  logic [22:0] trial;
  logic [37:0] product;
  logic [21:0] rem_q;

  assign in_time   = s_tdata[31:0];
  assign in_carbs  = s_tdata[47:32];
  assign in_absorb = s_tdata[63:48];

  assign s_tready  = (state == cobt_pkg::S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // Limit in force: zero or above the depth means the whole table.
  always_comb begin
    if (table_limit == 6'd0 || 32'(table_limit) > 32'(TABLE_DEPTH)) begin
      lim = CW'(TABLE_DEPTH);
    end else begin
      lim = CW'(table_limit);
    end
  end

  assign add_ok = (in_time != 32'd0) && (in_time >= last_meal_time) &&
                  (in_time >= last_update_time);
  assign upd_ok = (in_time >= last_update_time);

  // Entry check on the record just read.
  assign dur_s    = 22'(rd.duration) * 22'(cobt_pkg::SECONDS_PER_MINUTE);
  assign age      = now - rd.meal_time;
  assign check_ok = valid[idx[AW-1:0]] && (rd.meal_time <= now) && (dur_s != 22'd0) &&
                    (age < 32'(dur_s));
  assign rem      = dur_s - age[21:0];
  assign walk_last = (idx + CW'(1) >= held_walk);

  assign product = 38'(rec.carbs) * 38'(rem_q);
  assign trial   = {rdiv, low[QW-1]};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cobt_pkg::S_IDLE: begin
        if (in_fire) begin
          if (s_tuser == cobt_pkg::CMD_ADD) begin
            state_next = add_ok ? cobt_pkg::S_WRAP : cobt_pkg::S_EMIT;
          end else if (!upd_ok) begin
            state_next = cobt_pkg::S_EMIT;
          end else if (held == '0) begin
            state_next = cobt_pkg::S_FINISH;
          end else begin
            state_next = cobt_pkg::S_READ;
          end
        end
      end
      cobt_pkg::S_READ:  state_next = cobt_pkg::S_CHECK;
      cobt_pkg::S_CHECK: begin
        if (check_ok) begin
          state_next = cobt_pkg::S_MUL;
        end else begin
          state_next = walk_last ? cobt_pkg::S_FINISH : cobt_pkg::S_READ;
        end
      end
      cobt_pkg::S_MUL: state_next = cobt_pkg::S_DIV;
      cobt_pkg::S_DIV: begin
        if (cnt == NW'(QW - 1)) state_next = cobt_pkg::S_ACC;
      end
      cobt_pkg::S_ACC:    state_next = walk_last ? cobt_pkg::S_FINISH : cobt_pkg::S_READ;
      cobt_pkg::S_FINISH: state_next = cobt_pkg::S_WRAP;
      cobt_pkg::S_WRAP: begin
        if (ptr < lim) state_next = cobt_pkg::S_EMIT;
      end
      cobt_pkg::S_EMIT: begin
        if (!out_valid || m_tready) state_next = cobt_pkg::S_IDLE;
      end
      default: state_next = cobt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cobt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_absorb_minutes <= cobt_pkg::FALLBACK_ABSORB_MINUTES;
      table_limit         <= 6'(TABLE_DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cobt_pkg::REG_DEFAULT_ABSORPTION: dflt_absorb_minutes <= cfg_data;
        cobt_pkg::REG_TABLE_LIMIT:        table_limit <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Table memory: one write port, one registered read port at the walk index.
  always_ff @(posedge clk) begin
    rd <= mem[idx[AW-1:0]];
    if (state == cobt_pkg::S_IDLE && in_fire && s_tuser == cobt_pkg::CMD_ADD && add_ok) begin
      mem[ptr[AW-1:0]] <= '{
        duration:  (in_absorb != 16'd0) ? in_absorb :
                   ((dflt_absorb_minutes != 16'd0) ? dflt_absorb_minutes :
                    cobt_pkg::FALLBACK_ABSORB_MINUTES),
        carbs:     in_carbs,
        meal_time: in_time
      };
    end else if (state == cobt_pkg::S_ACC) begin
      // Compaction writes only at or below the entry being read, never ahead.
      mem[kept[AW-1:0]] <= rec;
    end
  end

  // Control state and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid            <= '0;
      ptr              <= '0;
      held             <= '0;
      last_update_time <= '0;
      last_meal_time   <= '0;
      cob_total        <= '0;
      accepted         <= 1'b0;
      idx              <= '0;
      kept             <= '0;
    end else begin
      case (state)
        cobt_pkg::S_IDLE: begin
          if (in_fire) begin
            if (s_tuser == cobt_pkg::CMD_ADD) begin
              accepted <= add_ok;
              if (add_ok) begin
                valid[ptr[AW-1:0]] <= 1'b1;
                ptr                <= ptr + CW'(1);
                last_meal_time     <= in_time;
                if (held < lim) held <= held + CW'(1);
              end
            end else begin
              accepted <= upd_ok;
              if (upd_ok) begin
                last_update_time <= in_time;
                idx              <= '0;
                kept             <= '0;
              end
            end
          end
        end
        cobt_pkg::S_CHECK: begin
          if (!check_ok) idx <= idx + CW'(1);
        end
        cobt_pkg::S_ACC: begin
          valid[kept[AW-1:0]] <= 1'b1;
          kept <= kept + CW'(1);
          idx  <= idx + CW'(1);
        end
        cobt_pkg::S_FINISH: begin
          for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (CW'(j) >= kept) valid[j] <= 1'b0;
          end
          held <= kept;
          ptr  <= kept;
          cob_total <= (32'(sum) > 32'(cobt_pkg::COB_MAX)) ? cobt_pkg::COB_MAX : 21'(sum);
        end
        cobt_pkg::S_WRAP: begin
          if (ptr >= lim) ptr <= ptr - lim;
        end
        default: ;
      endcase
    end
  end

  // Walk datapath: check, multiply, restoring divide, accumulate.
  always_ff @(posedge clk) begin
    case (state)
      cobt_pkg::S_IDLE: begin
        now       <= in_time;
        held_walk <= held;
        sum       <= '0;
      end
      cobt_pkg::S_CHECK: begin
        rec     <= rd;
        divisor <= dur_s;
      end
      cobt_pkg::S_MUL: begin
        rdiv <= product[37:QW];
        low  <= product[QW-1:0];
        quot <= '0;
        cnt  <= '0;
        // The multiply uses the remaining time held from the check.
      end
      cobt_pkg::S_DIV: begin
        if (trial >= {1'b0, divisor}) begin
          rdiv <= 22'(trial - {1'b0, divisor});
          quot <= {quot[QW-2:0], 1'b1};
        end else begin
          rdiv <= trial[21:0];
          quot <= {quot[QW-2:0], 1'b0};
        end
        low <= {low[QW-2:0], 1'b0};
        cnt <= cnt + NW'(1);
      end
      cobt_pkg::S_ACC: begin
        sum <= sum + SW'(quot);
      end
      default: ;
    endcase
  end

  // Output register; it frees as soon as the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == cobt_pkg::S_EMIT && (!out_valid || m_tready)) begin
      out_valid <= 1'b1;
      out_data  <= {4'd0, 6'(held), cob_total, accepted};
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // The remaining time must be held from the check into the multiply.
  always_ff @(posedge clk) begin
    if (state == cobt_pkg::S_CHECK) rem_q <= rem;
  end

  assert property (@(posedge clk) disable iff (rst) held <= CW'(TABLE_DEPTH))
    else $error("held count exceeds table depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == cobt_pkg::S_ACC || state == cobt_pkg::S_CHECK) |-> kept <= idx)
    else $error("compaction write ahead of read index");

  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state != cobt_pkg::S_IDLE)
    else $error("command accepted without starting work");

endmodule

// ===== sim/carbs_on_board_table_checker.sv =====
// Checker for the carbs-on-board table: predicts each result and compares it.
`timescale 1ns / 100ps

module carbs_on_board_table_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // time_s[31:0], carbs[47:32], absorb_minutes[63:48]
  input  logic        s_tuser,   // command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // accepted[0], carbs_on_board[21:1], meal_count[27:22]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  // Laid out as on m_tdata, the most significant field first.
  typedef struct packed {
    logic [5:0]  count;
    logic [20:0] cob;
    logic        accepted;
  } cob_result_t;

  // Shadow copy of the meal table and its bookkeeping.
  logic [31:0] tbl_time [TABLE_DEPTH];
  logic [15:0] tbl_carbs [TABLE_DEPTH];
  logic [15:0] tbl_dur [TABLE_DEPTH];
  logic        tbl_valid [TABLE_DEPTH];
  int unsigned wr_ptr;
  int unsigned held;
  logic [31:0] last_update;
  logic [31:0] last_meal;
  logic [20:0] cob_now;
  logic [15:0] dflt_min;
  logic [5:0]  limit_reg;

  cob_result_t expected_results[$];

  function automatic int unsigned eff_limit();
    if (limit_reg == 0 || limit_reg > TABLE_DEPTH) return TABLE_DEPTH;
    return limit_reg;
  endfunction

  // Apply one command to the shadow table and return the resulting output.
  function automatic cob_result_t predict_command(logic cmd, logic [31:0] t,
                                                 logic [15:0] carbs, logic [15:0] absorb);
    cob_result_t res;
    int unsigned lim;
    int unsigned kept;
    longint unsigned sum;
    longint unsigned age;
    longint unsigned dur_s;
    lim = eff_limit();
    res.accepted = 1'b1;
    if (cmd == cobt_pkg::CMD_ADD) begin
      if (absorb == 0)
        absorb = (dflt_min == 0) ? cobt_pkg::FALLBACK_ABSORB_MINUTES : dflt_min;
      if (t == 0 || t < last_meal || t < last_update) begin
        res.accepted = 1'b0;
      end else begin
        tbl_time[wr_ptr % TABLE_DEPTH]  = t;
        tbl_carbs[wr_ptr % TABLE_DEPTH] = carbs;
        tbl_dur[wr_ptr % TABLE_DEPTH]   = absorb;
        tbl_valid[wr_ptr % TABLE_DEPTH] = 1'b1;
        wr_ptr = ((wr_ptr % TABLE_DEPTH) + 1) % lim;
        if (held < lim) held++;
        last_meal = t;
      end
    end else if (t < last_update) begin
      res.accepted = 1'b0;
    end else begin
      // Walk the held records, keep the live ones in order and sum them.
      last_update = t;
      kept = 0;
      sum = 0;
      for (int i = 0; i < held && i < TABLE_DEPTH; i++) begin
        if (tbl_valid[i] && tbl_time[i] <= t) begin
          age = t - tbl_time[i];
          dur_s = longint'(tbl_dur[i]) * 60;
          if (dur_s != 0 && age < dur_s) begin
            sum += (longint'(tbl_carbs[i]) * (dur_s - age)) / dur_s;
            tbl_time[kept]  = tbl_time[i];
            tbl_carbs[kept] = tbl_carbs[i];
            tbl_dur[kept]   = tbl_dur[i];
            tbl_valid[kept] = 1'b1;
            kept++;
          end
        end
      end
      for (int i = kept; i < TABLE_DEPTH; i++) begin
        tbl_time[i] = '0;
        tbl_carbs[i] = '0;
        tbl_dur[i] = '0;
        tbl_valid[i] = 1'b0;
      end
      held = kept;
      wr_ptr = kept % lim;
      cob_now = (sum > cobt_pkg::COB_MAX) ? cobt_pkg::COB_MAX : sum[20:0];
    end
    res.cob = cob_now;
    res.count = held[5:0];
    return res;
  endfunction

  // Track configuration, commands and results at each clock edge.
  always @(posedge clk) begin
    cob_result_t want;
    cob_result_t got;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        tbl_time[i] = '0;
        tbl_carbs[i] = '0;
        tbl_dur[i] = '0;
        tbl_valid[i] = 1'b0;
      end
      wr_ptr = 0;
      held = 0;
      last_update = '0;
      last_meal = '0;
      cob_now = '0;
      dflt_min = cobt_pkg::FALLBACK_ABSORB_MINUTES;
      limit_reg = 6'd32;
      expected_results.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cobt_pkg::REG_DEFAULT_ABSORPTION) dflt_min = cfg_data;
        else limit_reg = cfg_data[5:0];
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_command(s_tuser, s_tdata[31:0],
                                                   s_tdata[47:32], s_tdata[63:48]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[27:0];
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %h", $time, m_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.accepted !== want.accepted || got.cob !== want.cob ||
              got.count !== want.count) begin
            $display("%0t: expected acc=%0d cob=%0d cnt=%0d, actual acc=%0d cob=%0d cnt=%0d",
                     $time, want.accepted, want.cob, want.count,
                     got.accepted, got.cob, got.count);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== sim/carbs_on_board_table_core_tb.sv =====
// Testbench top for the carbs-on-board table: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module carbs_on_board_table_core_tb;

  localparam int STALL_LIMIT = 6000;
  localparam int PHASE_ITEMS = 122;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // time_s[31:0], carbs[47:32], absorb_minutes[63:48]
  logic        s_tuser;   // command
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // accepted[0], carbs_on_board[21:1], meal_count[27:22]
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          quiet_cycles;
  int          no_gap_run;
  int          rx_stall;
  longint      now_s;

  always #6 clk = ~clk;

  carbs_on_board_table_core u_top (.*);

  carbs_on_board_table_checker u_checker (.*);

  // Mostly no gap, else a short gap or now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver readiness with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      rx_stall <= pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_cmd(logic cmd, logic [31:0] t, logic [15:0] carbs,
                          logic [15:0] absorb);
    int gap;
    gap = (no_gap_run > 0) ? 0 : pick_gap();
    if (no_gap_run > 0) no_gap_run--;
    else if ($urandom_range(0, 29) == 0) no_gap_run = $urandom_range(8, 30);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {absorb, carbs, t};
    @(posedge clk iff s_tready);
  endtask

  // Stop sending and wait until every result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random command: mostly a well-formed add or update moving forward.
  task automatic random_cmd();
    int r;
    logic [15:0] absorb;
    logic [31:0] t;
    r = $urandom_range(0, 99);
    absorb = 16'($urandom_range(1, 240));
    if ($urandom_range(0, 9) == 0) absorb = 16'd0;
    else if ($urandom_range(0, 19) == 0) absorb = 16'($urandom);
    if (r < 75) begin
      if ($urandom_range(0, 19) == 0) now_s += $urandom_range(5000, 50000);
      else if ($urandom_range(0, 4) != 0) now_s += $urandom_range(0, 900);
      if (now_s > 64'hFFFF_FFFF) now_s = 64'hFFFF_FFFF;
      send_cmd(($urandom_range(0, 9) < 6) ? cobt_pkg::CMD_ADD : cobt_pkg::CMD_UPDATE,
               now_s[31:0], 16'($urandom), absorb);
    end else if (r < 82) begin
      send_cmd(cobt_pkg::CMD_ADD, 32'd0, 16'($urandom), absorb);
    end else if (r < 90) begin
      send_cmd(cobt_pkg::CMD_ADD, $urandom_range(0, now_s[31:0]), 16'($urandom), absorb);
    end else if (r < 97) begin
      send_cmd(cobt_pkg::CMD_UPDATE, $urandom_range(0, now_s[31:0]), 16'($urandom), absorb);
    end else begin
      // Occasional jump to an arbitrary time while the clock is still low.
      t = $urandom;
      if (now_s < 64'h8000_0000 && t > now_s) now_s = t;
      send_cmd(1'($urandom_range(0, 1)), t, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] dflt_list [6];
    logic [15:0] lim_list [6];
    dflt_list = '{16'd180, 16'd0, 16'd1, 16'hFFFF, 16'd45, 16'd300};
    lim_list  = '{16'd32, 16'd1, 16'd0, 16'd63, 16'd5, 16'd3};
    rst = 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= cobt_pkg::CMD_ADD;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= cobt_pkg::REG_DEFAULT_ABSORPTION;
    cfg_data <= '0;
    no_gap_run = 0;
    now_s = 1000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(cobt_pkg::REG_DEFAULT_ABSORPTION, dflt_list[ph]);
      write_reg(cobt_pkg::REG_TABLE_LIMIT, lim_list[ph]);
      if (ph == 0) begin
        // Directed: boundaries, rejections, future and expired records.
        send_cmd(cobt_pkg::CMD_UPDATE, 32'd0, 16'd0, 16'd0);
        send_cmd(cobt_pkg::CMD_ADD, 32'd0, 16'd5, 16'd5);
        send_cmd(cobt_pkg::CMD_ADD, 32'd100, 16'hFFFF, 16'd0);
        send_cmd(cobt_pkg::CMD_ADD, 32'd50, 16'd7, 16'd7);
        send_cmd(cobt_pkg::CMD_ADD, 32'd100, 16'd0, 16'hFFFF);
        send_cmd(cobt_pkg::CMD_ADD, 32'd200, 16'd1000, 16'd1);
        send_cmd(cobt_pkg::CMD_UPDATE, 32'd150, 16'd0, 16'd0);
        send_cmd(cobt_pkg::CMD_UPDATE, 32'd100, 16'd0, 16'd0);
        send_cmd(cobt_pkg::CMD_ADD, 32'd160, 16'd16, 16'd1);
        send_cmd(cobt_pkg::CMD_UPDATE, 32'd220, 16'd0, 16'd0);
        send_cmd(cobt_pkg::CMD_UPDATE, 32'd220, 16'd0, 16'd0);
        send_cmd(cobt_pkg::CMD_ADD, 32'd219, 16'd9, 16'd9);
        for (int i = 0; i < 33; i++)
          send_cmd(cobt_pkg::CMD_ADD, 32'd300 + i, 16'hFFFF, 16'hFFFF);
        send_cmd(cobt_pkg::CMD_UPDATE, 32'd332, 16'd0, 16'd0);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) drain();
        random_cmd();
      end
      drain();
    end

    // Close with the latest possible time.
    send_cmd(cobt_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
    send_cmd(cobt_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 16'd0, 16'd0);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
